FILE: rtl/acd_pkg.sv
// Shared types, constants and byte functions for the AES-256 CBC decrypt unit.
// No dependencies.
`timescale 1ns / 1ps

package acd_pkg;

   localparam int ROUND_KEY_COUNT = 15;
   localparam int LAST_ROUND      = ROUND_KEY_COUNT - 1;
   localparam int SCHED_WORDS     = ROUND_KEY_COUNT * 4;
   localparam int KEY_WORDS       = 8;
   localparam int RK_ADDR_W       = $clog2(ROUND_KEY_COUNT);
   localparam int WORD_IDX_W      = $clog2(SCHED_WORDS);
   localparam int CSR_INDEX_W     = 3;

   localparam logic [CSR_INDEX_W-1:0] REG_KEY_PART_0  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_KEY_PART_1  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_KEY_PART_2  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_KEY_PART_3  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_INIT_VEC_HI = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_INIT_VEC_LO = 3'd5;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ROUND,
      ST_FINAL
   } state_type;

   localparam logic [2047:0] SBOX_TAB = {
      128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
      128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
      128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
      128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
      128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
      128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
      128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
      128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16};

   localparam logic [2047:0] INV_SBOX_TAB = {
      128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
      128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
      128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
      128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
      128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
      128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
      128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
      128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d};

   function automatic logic [7:0] sbox(input logic [7:0] x);
      return SBOX_TAB[2047 - 8 * x -: 8];
   endfunction

   function automatic logic [7:0] inv_sbox(input logic [7:0] x);
      return INV_SBOX_TAB[2047 - 8 * x -: 8];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
   endfunction

   // column a0..a3 with a0 in the top byte
   function automatic logic [31:0] inv_mix_col(input logic [31:0] col);
      logic [7:0] a [4];
      logic [7:0] x2 [4];
      logic [7:0] x4 [4];
      logic [7:0] x8 [4];
      logic [7:0] m9 [4];
      logic [7:0] m11 [4];
      logic [7:0] m13 [4];
      logic [7:0] m14 [4];
      for (int k = 0; k < 4; k++) begin
         a[k]   = col[31 - 8 * k -: 8];
         x2[k]  = xtime(a[k]);
         x4[k]  = xtime(x2[k]);
         x8[k]  = xtime(x4[k]);
         m9[k]  = x8[k] ^ a[k];
         m11[k] = x8[k] ^ x2[k] ^ a[k];
         m13[k] = x8[k] ^ x4[k] ^ a[k];
         m14[k] = x8[k] ^ x4[k] ^ x2[k];
      end
      return {m14[0] ^ m11[1] ^ m13[2] ^ m9[3],
              m9[0] ^ m14[1] ^ m11[2] ^ m13[3],
              m13[0] ^ m9[1] ^ m14[2] ^ m11[3],
              m11[0] ^ m13[1] ^ m9[2] ^ m14[3]};
   endfunction

   // state byte 4c+r sits at bits 127-8(4c+r)
   function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
      logic [127:0] t;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[127 - 8 * (4 * c + r) -: 8] =
               inv_sbox(s[127 - 8 * (4 * ((c - r + 4) % 4) + r) -: 8]);
         end
      end
      return t;
   endfunction

endpackage

FILE: rtl/acd_key_expand.sv
// AES-256 key schedule generator, one word per cycle, and the round key banks.
// Depends on acd_pkg.
`timescale 1ns / 1ps

module acd_key_expand (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [255:0]                  key,
   input  logic [acd_pkg::RK_ADDR_W-1:0] rd_addr,
   output logic                          busy,
   output logic [127:0]                  round_key
);

   logic [63:0] even_mem [acd_pkg::ROUND_KEY_COUNT];
   logic [63:0] odd_mem  [acd_pkg::ROUND_KEY_COUNT];

   logic                            busy_ff;
   logic [acd_pkg::WORD_IDX_W-1:0]  cnt_ff;
   logic [7:0]                      rc_ff;
   logic [31:0]                     win_ff [acd_pkg::KEY_WORDS];
   logic [31:0]                     prev_ff;
   logic [127:0]                    rk_ff;

   logic [31:0] key_word;
   logic [31:0] tmp;
   logic [31:0] word_in;

   always_comb begin
      key_word = key[255 - 32 * cnt_ff[2:0] -: 32];
      case (cnt_ff[2:0])
         3'd0:    tmp = acd_pkg::sub_word({win_ff[7][23:0], win_ff[7][31:24]}) ^ {rc_ff, 24'd0};
         3'd4:    tmp = acd_pkg::sub_word(win_ff[7]);
         default: tmp = win_ff[7];
      endcase
      word_in = (cnt_ff < acd_pkg::WORD_IDX_W'(acd_pkg::KEY_WORDS)) ? key_word
                                                                     : (win_ff[0] ^ tmp);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
         rc_ff   <= 8'h01;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
         rc_ff   <= 8'h01;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == acd_pkg::WORD_IDX_W'(acd_pkg::SCHED_WORDS - 1)) begin
            busy_ff <= 1'b0;
         end
         if (cnt_ff[2:0] == 3'd0 && cnt_ff >= acd_pkg::WORD_IDX_W'(acd_pkg::KEY_WORDS)) begin
            rc_ff <= acd_pkg::xtime(rc_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         for (int k = 0; k < acd_pkg::KEY_WORDS - 1; k++) begin
            win_ff[k] <= win_ff[k + 1];
         end
         win_ff[acd_pkg::KEY_WORDS - 1] <= word_in;
         prev_ff <= word_in;
         if (cnt_ff[0]) begin
            if (cnt_ff[1]) begin
               odd_mem[cnt_ff[5:2]] <= {prev_ff, word_in};
            end else begin
               even_mem[cnt_ff[5:2]] <= {prev_ff, word_in};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rk_ff <= {even_mem[rd_addr], odd_mem[rd_addr]};
   end

   assign busy      = busy_ff;
   assign round_key = rk_ff;

endmodule

FILE: rtl/acd_round.sv
// Shared inverse round: InvShiftRows, InvSubBytes, AddRoundKey, InvMixColumns (skipped in the final round).
// Depends on acd_pkg.
`timescale 1ns / 1ps

module acd_round (
   input  logic [127:0] state_in,
   input  logic [127:0] round_key,
   input  logic         final_round,
   output logic [127:0] state_out
);

   logic [127:0] keyed;
   logic [127:0] mixed;

   always_comb begin
      keyed = acd_pkg::inv_shift_sub(state_in) ^ round_key;
      for (int c = 0; c < 4; c++) begin
         mixed[127 - 32 * c -: 32] = acd_pkg::inv_mix_col(keyed[127 - 32 * c -: 32]);
      end
      state_out = final_round ? keyed : mixed;
   end

endmodule

FILE: rtl/aes256_cbc_decrypt_unit.sv
// AES-256 CBC decrypt unit: control, chaining and ports.
// Depends on acd_pkg, acd_key_expand and acd_round.
//
//  channel | dir | handshake            | payload
//  req     | in  | req_tvalid/tready    | tdata block_hi,block_lo; tuser first; tlast last
//  rsp     | out | rsp_tvalid/tready    | tdata plain_hi,plain_lo,pad_length; tlast is_last
//  csr     | in  | csr_valid/csr_ready  | csr_index, csr_data
//
// After the block transfer, the result takes a load state and 14 passes of the shared
// round unit, one round per cycle until the final round, which can wait, with round keys read from two banks.
// The next transfer is taken only back in the idle state, once the block is done.
// After reset and after each key write the schedule is built, one word a cycle;
// req_tready and csr_ready stay low meanwhile.
// A finished block waits in the final round until the result register is free.
`timescale 1ns / 1ps

module aes256_cbc_decrypt_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [127:0]                    req_tdata,  // block_hi, block_lo
   input  logic                            req_tuser,  // first_block
   input  logic                            req_tlast,  // last_block
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [135:0]                    rsp_tdata,  // plain_hi, plain_lo, pad_length
   output logic                            rsp_tlast,  // is_last
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [acd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [63:0]                     csr_data
);

   acd_pkg::state_type state_ff, state_in;
   logic [acd_pkg::RK_ADDR_W-1:0] rd_ff, rd_in;
   logic [acd_pkg::RK_ADDR_W-1:0] rd_addr;

   logic [127:0] st_ff;
   logic [127:0] blk_ff;
   logic         first_ff;
   logic         last_ff;
   logic [127:0] chain_ff;
   logic [255:0] key_ff;
   logic [127:0] iv_ff;
   logic         rsp_valid_ff;
   logic [135:0] rsp_data_ff;
   logic         rsp_last_ff;

   logic         kx_busy;
   logic         kx_start;
   logic [127:0] round_key;
   logic [127:0] round_out;
   logic [127:0] plain;
   logic         req_xfer;
   logic         csr_xfer;
   logic         done;
   logic         rsp_free;

   assign req_tready = (state_ff == acd_pkg::ST_IDLE) && !kx_busy;
   assign csr_ready  = !kx_busy;
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_xfer   = csr_valid && csr_ready;
   assign kx_start   = csr_xfer && (csr_index == acd_pkg::REG_KEY_PART_0 ||
                                    csr_index == acd_pkg::REG_KEY_PART_1 ||
                                    csr_index == acd_pkg::REG_KEY_PART_2 ||
                                    csr_index == acd_pkg::REG_KEY_PART_3);
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   acd_key_expand u_key_expand (
      .clock     (clock),
      .reset     (reset),
      .start     (kx_start),
      .key       (key_ff),
      .rd_addr   (rd_addr),
      .busy      (kx_busy),
      .round_key (round_key)
   );

   acd_round u_round (
      .state_in    (st_ff),
      .round_key   (round_key),
      .final_round (state_ff == acd_pkg::ST_FINAL),
      .state_out   (round_out)
   );

   assign plain = round_out ^ (first_ff ? iv_ff : chain_ff);

   always_comb begin
      state_in = state_ff;
      rd_in    = rd_ff;
      rd_addr  = acd_pkg::RK_ADDR_W'(acd_pkg::LAST_ROUND);
      done     = 1'b0;
      case (state_ff)
         acd_pkg::ST_IDLE: begin
            if (req_xfer) begin
               state_in = acd_pkg::ST_LOAD;
            end
         end
         acd_pkg::ST_LOAD: begin
            rd_addr  = acd_pkg::RK_ADDR_W'(acd_pkg::LAST_ROUND - 1);
            rd_in    = acd_pkg::RK_ADDR_W'(acd_pkg::LAST_ROUND - 1);
            state_in = acd_pkg::ST_ROUND;
         end
         acd_pkg::ST_ROUND: begin
            rd_addr = rd_ff - 1'b1;
            rd_in   = rd_ff - 1'b1;
            if (rd_ff == acd_pkg::RK_ADDR_W'(1)) begin
               state_in = acd_pkg::ST_FINAL;
            end
         end
         acd_pkg::ST_FINAL: begin
            rd_addr = '0;
            if (rsp_free) begin
               done     = 1'b1;
               state_in = acd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = acd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= acd_pkg::ST_IDLE;
         rd_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         chain_ff     <= '0;
         key_ff       <= '0;
         iv_ff        <= '0;
      end else begin
         state_ff <= state_in;
         rd_ff    <= rd_in;
         if (done) begin
            rsp_valid_ff <= 1'b1;
            chain_ff     <= blk_ff;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_xfer) begin
            case (csr_index)
               acd_pkg::REG_KEY_PART_0:  key_ff[255:192] <= csr_data;
               acd_pkg::REG_KEY_PART_1:  key_ff[191:128] <= csr_data;
               acd_pkg::REG_KEY_PART_2:  key_ff[127:64]  <= csr_data;
               acd_pkg::REG_KEY_PART_3:  key_ff[63:0]    <= csr_data;
               acd_pkg::REG_INIT_VEC_HI: iv_ff[127:64]   <= csr_data;
               acd_pkg::REG_INIT_VEC_LO: iv_ff[63:0]     <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         blk_ff   <= {req_tdata[63:0], req_tdata[127:64]};
         first_ff <= req_tuser;
         last_ff  <= req_tlast;
      end
      case (state_ff)
         acd_pkg::ST_LOAD:  st_ff <= blk_ff ^ round_key;
         acd_pkg::ST_ROUND: st_ff <= round_out;
         default: ;
      endcase
      if (done) begin
         rsp_data_ff <= {(last_ff ? plain[7:0] : 8'd0), plain[63:0], plain[127:64]};
         rsp_last_ff <= last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   a_no_accept_while_expanding: assert property (@(posedge clock) disable iff (reset)
      kx_busy |-> !req_tready && !csr_ready)
      else $error("transfer possible during key expansion");

   a_accept_starts_load: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> state_ff == acd_pkg::ST_LOAD)
      else $error("accepted block did not start");

   a_round_index_live: assert property (@(posedge clock) disable iff (reset)
      state_ff == acd_pkg::ST_ROUND |-> rd_ff != '0)
      else $error("round counter underflow");

   a_result_after_final: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff) == acd_pkg::ST_FINAL)
      else $error("result without final round");
`endif

endmodule

FILE: test/aes256_cbc_decrypt_unit_checker.sv
// Checker for the AES-256 CBC decrypt unit: watches the req, rsp and csr channels,
// predicts each plaintext block and compares it with the unit's output.
// Depends on acd_pkg for the register indexes.
`timescale 1ns / 1ps

module aes256_cbc_decrypt_unit_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [127:0]                    req_tdata,  // block_hi, block_lo
   input  logic                            req_tuser,  // first_block
   input  logic                            req_tlast,  // last_block
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [135:0]                    rsp_tdata,  // plain_hi, plain_lo, pad_length
   input  logic                            rsp_tlast,  // is_last
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [acd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [63:0]                     csr_data,
   output int                              failures,
   output int                              pending,
   output int                              blocks_checked
);

   typedef struct {
      logic [63:0] plain_hi;
      logic [63:0] plain_lo;
      logic        is_last;
      logic [7:0]  pad_length;
   } plain_block_type;

   plain_block_type plain_q[$];
   logic [63:0]  key_reg [4];
   logic [63:0]  iv_reg [2];
   logic [63:0]  chain_reg [2];
   logic [31:0]  sched [60];

   function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      p = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[0]) p ^= a;
         a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
         b = b >> 1;
      end
      return p;
   endfunction

   function automatic logic [7:0] ginv(input logic [7:0] a);
      logic [7:0] r;
      logic [7:0] base;
      int         e;
      r = 8'h01;
      base = a;
      e = 254;
      while (e != 0) begin
         if (e & 1) r = gmul(r, base);
         base = gmul(base, base);
         e = e >> 1;
      end
      return r;
   endfunction

   function automatic logic [7:0] rotl(input logic [7:0] x, input int n);
      return (x << n) | (x >> (8 - n));
   endfunction

   function automatic logic [7:0] fwd_sub(input logic [7:0] x);
      logic [7:0] b;
      b = ginv(x);
      return b ^ rotl(b, 1) ^ rotl(b, 2) ^ rotl(b, 3) ^ rotl(b, 4) ^ 8'h63;
   endfunction

   function automatic logic [7:0] rev_sub(input logic [7:0] y);
      return ginv(rotl(y, 1) ^ rotl(y, 3) ^ rotl(y, 6) ^ 8'h05);
   endfunction

   function automatic void expand_schedule();
      logic [31:0] t;
      logic [7:0]  rc;
      rc = 8'h01;
      for (int i = 0; i < 8; i++)
         sched[i] = (i % 2) ? key_reg[i / 2][31:0] : key_reg[i / 2][63:32];
      for (int i = 8; i < 60; i++) begin
         t = sched[i - 1];
         if (i % 8 == 0) begin
            t = {t[23:0], t[31:24]};
            t = {fwd_sub(t[31:24]) ^ rc, fwd_sub(t[23:16]),
                 fwd_sub(t[15:8]), fwd_sub(t[7:0])};
            rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
         end else if (i % 8 == 4) begin
            t = {fwd_sub(t[31:24]), fwd_sub(t[23:16]), fwd_sub(t[15:8]), fwd_sub(t[7:0])};
         end
         sched[i] = sched[i - 8] ^ t;
      end
   endfunction

   // state byte k sits at bits 127-8k; byte k is row k%4, column k/4
   function automatic logic [127:0] add_key(input logic [127:0] s, input int rd);
      return s ^ {sched[4 * rd], sched[4 * rd + 1], sched[4 * rd + 2], sched[4 * rd + 3]};
   endfunction

   function automatic logic [127:0] unshift_unsub(input logic [127:0] s);
      logic [127:0] t;
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++)
            t[127 - 8 * (4 * c + r) -: 8] =
               rev_sub(s[127 - 8 * (4 * ((c - r + 4) % 4) + r) -: 8]);
      return t;
   endfunction

   function automatic logic [127:0] unmix(input logic [127:0] s);
      logic [127:0] t;
      logic [7:0]   a0, a1, a2, a3;
      for (int c = 0; c < 4; c++) begin
         a0 = s[127 - 32 * c -: 8];
         a1 = s[119 - 32 * c -: 8];
         a2 = s[111 - 32 * c -: 8];
         a3 = s[103 - 32 * c -: 8];
         t[127 - 32 * c -: 8] = gmul(a0, 8'd14) ^ gmul(a1, 8'd11) ^ gmul(a2, 8'd13) ^
                                gmul(a3, 8'd9);
         t[119 - 32 * c -: 8] = gmul(a0, 8'd9) ^ gmul(a1, 8'd14) ^ gmul(a2, 8'd11) ^
                                gmul(a3, 8'd13);
         t[111 - 32 * c -: 8] = gmul(a0, 8'd13) ^ gmul(a1, 8'd9) ^ gmul(a2, 8'd14) ^
                                gmul(a3, 8'd11);
         t[103 - 32 * c -: 8] = gmul(a0, 8'd11) ^ gmul(a1, 8'd13) ^ gmul(a2, 8'd9) ^
                                gmul(a3, 8'd14);
      end
      return t;
   endfunction

   function automatic plain_block_type decrypt_block(input logic [63:0] hi,
                                                     input logic [63:0] lo,
                                                     input logic first, input logic last);
      logic [127:0] s;
      plain_block_type p;
      s = add_key({hi, lo}, 14);
      for (int rd = 13; rd > 0; rd--)
         s = unmix(add_key(unshift_unsub(s), rd));
      s = add_key(unshift_unsub(s), 0);
      p.plain_hi   = s[127:64] ^ (first ? iv_reg[0] : chain_reg[0]);
      p.plain_lo   = s[63:0] ^ (first ? iv_reg[1] : chain_reg[1]);
      p.is_last    = last;
      p.pad_length = last ? p.plain_lo[7:0] : 8'h00;
      chain_reg[0] = hi;
      chain_reg[1] = lo;
      return p;
   endfunction

   always @(posedge clock) begin
      plain_block_type want;
      if (reset) begin
         for (int i = 0; i < 4; i++) key_reg[i] = '0;
         iv_reg[0] = '0;
         iv_reg[1] = '0;
         chain_reg[0] = '0;
         chain_reg[1] = '0;
         expand_schedule();
         plain_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               acd_pkg::REG_KEY_PART_0, acd_pkg::REG_KEY_PART_1,
               acd_pkg::REG_KEY_PART_2, acd_pkg::REG_KEY_PART_3: begin
                  key_reg[csr_index[1:0]] = csr_data;
                  expand_schedule();
               end
               acd_pkg::REG_INIT_VEC_HI: iv_reg[0] = csr_data;
               acd_pkg::REG_INIT_VEC_LO: iv_reg[1] = csr_data;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (plain_q.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("unexpected plaintext transfer: %h last %b", rsp_tdata, rsp_tlast);
            end else begin
               want = plain_q.pop_front();
               blocks_checked++;
               if (rsp_tdata[63:0] !== want.plain_hi || rsp_tdata[127:64] !== want.plain_lo ||
                   rsp_tlast !== want.is_last || rsp_tdata[135:128] !== want.pad_length) begin
                  failures++;
                  if (failures <= 10)
                     $display({"plaintext mismatch: exp %h %h last %b pad %h,",
                               " got %h %h last %b pad %h"},
                              want.plain_hi, want.plain_lo, want.is_last, want.pad_length,
                              rsp_tdata[63:0], rsp_tdata[127:64], rsp_tlast, rsp_tdata[135:128]);
               end
            end
         end
         if (req_tvalid && req_tready)
            plain_q.push_back(decrypt_block(req_tdata[63:0], req_tdata[127:64],
                                            req_tuser, req_tlast));
      end
      pending = plain_q.size();
   end

   initial begin
      failures = 0;
      pending = 0;
      blocks_checked = 0;
   end

endmodule

FILE: test/aes256_cbc_decrypt_unit_test.sv
// Testbench top for the AES-256 CBC decrypt unit: drives blocks and key/IV writes
// with random idling and hands checking to aes256_cbc_decrypt_unit_checker.
// Depends on acd_pkg, the unit and the checker.
`timescale 1ns / 1ps

module aes256_cbc_decrypt_unit_test;

   localparam logic [acd_pkg::CSR_INDEX_W-1:0] REG_UNUSED_6 = 3'd6;
   localparam logic [acd_pkg::CSR_INDEX_W-1:0] REG_UNUSED_7 = 3'd7;
   localparam int STALL_LIMIT = 3000;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [127:0]                    req_tdata = '0;
   logic                            req_tuser = 1'b0;
   logic                            req_tlast = 1'b0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [135:0]                    rsp_tdata;
   logic                            rsp_tlast;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [acd_pkg::CSR_INDEX_W-1:0] csr_index = acd_pkg::REG_KEY_PART_0;
   logic [63:0]                     csr_data = '0;
   int                              failures, pending, blocks_checked;
   int                              blocks_sent = 0;
   int                              messages = 0;
   int                              reg_writes = 0;
   int                              quiet_cycles = 0;
   bit                              calm = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   aes256_cbc_decrypt_unit dut (.*);

   aes256_cbc_decrypt_unit_checker checker_i (.*);

   always @(posedge clock)
      rsp_tready <= calm ? 1'b1 : ($urandom_range(99) >= 20);

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("aes256_cbc_decrypt_unit_test: done, errors");
         $finish;
      end
   end

   task automatic send_block(input logic [63:0] hi, input logic [63:0] lo,
                             input logic first, input logic last);
      if (!calm && $urandom_range(99) < 20) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {lo, hi};
      req_tuser  <= first;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      blocks_sent++;
   endtask

   function automatic logic [63:0] rand_word();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic send_message(input bit noisy);
      int n;
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++)
         if (noisy)
            send_block(rand_word(), rand_word(), 1'($urandom_range(1)),
                       1'($urandom_range(1)));
         else
            send_block(rand_word(), rand_word(), i == 0, i == n - 1);
      messages++;
   endtask

   task automatic write_reg(input logic [acd_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [63:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      reg_writes++;
   endtask

   // every block yields a result, so an empty queue means the unit is idle
   task automatic drain();
      req_tvalid <= 1'b0;
      csr_valid  <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic load_key_iv(input logic [63:0] k0, input logic [63:0] k1,
                              input logic [63:0] k2, input logic [63:0] k3,
                              input logic [63:0] ivh, input logic [63:0] ivl);
      drain();
      write_reg(acd_pkg::REG_KEY_PART_0, k0);
      write_reg(acd_pkg::REG_KEY_PART_1, k1);
      write_reg(acd_pkg::REG_KEY_PART_2, k2);
      write_reg(acd_pkg::REG_KEY_PART_3, k3);
      write_reg(acd_pkg::REG_INIT_VEC_HI, ivh);
      write_reg(acd_pkg::REG_INIT_VEC_LO, ivl);
      write_reg(REG_UNUSED_6, rand_word());
      write_reg(REG_UNUSED_7, rand_word());
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset key, not-first without history chains from zero
      send_block('0, '0, 1'b0, 1'b0);
      send_block('1, '1, 1'b0, 1'b1);
      send_block(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b1, 1'b0);
      send_block(64'h8000000000000001, 64'h00000000000000ff, 1'b0, 1'b1);
      load_key_iv('1, '1, '1, '1, '1, '1);
      for (int i = 0; i < 8; i++)
         send_block(i[0] ? '1 : '0, i[1] ? '1 : '0, i[2], i[0]);
      load_key_iv({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, '0, 64'h00000000000000ff);
      for (int i = 0; i < 8; i++)
         send_block({$urandom, $urandom}, {$urandom, $urandom}, i == 0, i % 4 == 3);

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: load_key_iv('0, '0, '0, '0, '0, '0);
            1: load_key_iv('1, '0, '1, '0, '1, '0);
            default: load_key_iv(rand_word(), rand_word(), rand_word(), rand_word(),
                                 rand_word(), rand_word());
         endcase
         calm = (phase == 3);
         while (blocks_sent < 20 + 225 * (phase + 1))
            send_message($urandom_range(99) < 15);
      end
      calm = 1'b0;

      drain();
      repeat (30) @(posedge clock);
      $display("covered %0d blocks in %0d messages, %0d results checked", blocks_sent,
               messages, blocks_checked);
      $display("%0d key/IV register writes over 9 key settings, unused indexes included",
               reg_writes);
      if (failures == 0)
         $display("aes256_cbc_decrypt_unit_test: done, clean");
      else
         $display("aes256_cbc_decrypt_unit_test: done, errors");
      $finish;
   end

endmodule
